[rtl/core/pwmavg_pkg.sv]
package pwmavg_pkg;

  // fixed field widths
  localparam int CH_IN_W = 3;
  localparam int US_W    = 13;
  localparam int FREQ_W  = 26;
  localparam int DUTY_W  = 7;

  // scale factors
  localparam int US_PER_S = 1000000;
  localparam int PERCENT  = 100;

  // per-divider status
  typedef struct packed {
    logic busy;
  } div_stat_t;

endpackage

[rtl/core/pwmavg_div.sv]
module pwmavg_div import pwmavg_pkg::*; #(
  parameter int NUM_W = 26,
  parameter int DEN_W = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output div_stat_t        stat,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] qsr;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, qsr[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      den_r <= den;
      qsr   <= num;
    end else if (busy) begin
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      qsr <= {qsr[NUM_W-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign quo       = qsr;

endmodule

[rtl/core/pwm_period_duty_averager.sv]
// sequence: a timeout or a bad channel goes from the input transfer straight to the result
//   register with zeros; any other item reads its channel entry and window slot, then divides
// flow: one item at a time; no new item is taken until the last result is in the output
//   register, and the two bit-serial dividers run side by side
// reset: after rst a clearing pass over every store address zeroes the sample store
//   and the per-channel sums before the first input transfer
module pwm_period_duty_averager import pwmavg_pkg::*; #(
  parameter int CHANNELS     = 8,
  parameter int WINDOW       = 50,
  parameter int MAX_PULSE_US = 5000
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CH_IN_W-1:0] channel,
  input  logic [US_W-1:0]    high_us,
  input  logic [US_W-1:0]    low_us,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CH_IN_W-1:0] channel_out,
  output logic [FREQ_W-1:0]  frequency_hz,
  output logic [DUTY_W-1:0]  duty_percent
);

  // storage geometry: channel and slot index the sample store as {channel, slot}
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int AW       = CH_W + SLOT_W;
  localparam int WIN_DEPTH = 1 << AW;
  localparam int CH_DEPTH  = 1 << CH_W;

  // sum widths: a window of 13-bit samples
  localparam int SUM_W  = US_W + $clog2(WINDOW);
  localparam int TOT_W  = SUM_W + 1;
  localparam int CHE_W  = 2 * SUM_W + SLOT_W;

  // division operands
  localparam int FREQ_NUM = US_PER_S * WINDOW;
  localparam int FNUM_W   = $clog2(FREQ_NUM + 1);
  localparam int DNUM_W   = SUM_W + DUTY_W;
  localparam int QW       = (FNUM_W > FREQ_W) ? FNUM_W : FREQ_W;
  localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

  // sequencer codes
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RDCH  = 3'd2;
  localparam logic [2:0] S_RDWIN = 3'd3;
  localparam logic [2:0] S_START = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [AW-1:0] clr_cnt;

  // sample store: {high, low} per slot, and per-channel {high_sum, low_sum, slot}
  logic [2*US_W-1:0] win_mem [WIN_DEPTH];
  logic [CHE_W-1:0]  chan_mem [CH_DEPTH];
  logic [2*US_W-1:0] win_rdata;
  logic [CHE_W-1:0]  chan_rdata;

  logic              win_we;
  logic [AW-1:0]     win_waddr;
  logic [AW-1:0]     win_raddr;
  logic [2*US_W-1:0] win_wdata;
  logic              chan_we;
  logic [CH_W-1:0]   chan_waddr;
  logic [CHE_W-1:0]  chan_wdata;

  // input side
  logic [6:0]        ch_ext;
  logic [CH_W-1:0]   ch_idx_in;
  logic              item_ok;
  logic [US_W-1:0]   hi_cl;
  logic [US_W-1:0]   lo_cl;
  logic              in_xfer;

  // item registers
  logic [CH_IN_W-1:0] ch_r;
  logic [CH_W-1:0]    ch_idx_r;
  logic [US_W-1:0]    hi_r;
  logic [US_W-1:0]    lo_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [SLOT_W-1:0]  slot_rd;
  logic [SLOT_W-1:0]  slot_next;
  logic [SUM_W-1:0]   hs_r;
  logic [SUM_W-1:0]   ls_r;
  logic [SUM_W-1:0]   hs_next;
  logic [SUM_W-1:0]   ls_next;
  logic [FREQ_W-1:0]  res_freq;
  logic [DUTY_W-1:0]  res_duty;

  // dividers
  logic              div_start;
  logic [TOT_W-1:0]  total;
  logic [DNUM_W-1:0] duty_num;
  div_stat_t         fdiv_stat;
  div_stat_t         ddiv_stat;
  logic [FNUM_W-1:0] fquo;
  logic [DNUM_W-1:0] dquo;
  logic [QW-1:0]     fquo_ext;
  logic [FREQ_W-1:0] freq_sat;
  logic              out_free;

  // channel check and width saturation
  assign ch_ext    = {{(7-CH_IN_W){1'b0}}, channel};
  assign ch_idx_in = ch_ext[CH_W-1:0];
  assign hi_cl = ({{(32-US_W){1'b0}}, high_us} > 32'(MAX_PULSE_US)) ?
                 US_W'(MAX_PULSE_US) : high_us;
  assign lo_cl = ({{(32-US_W){1'b0}}, low_us} > 32'(MAX_PULSE_US)) ?
                 US_W'(MAX_PULSE_US) : low_us;
  // timeout or unknown channel leaves the state alone and reports zeros
  assign item_ok = (high_us != '0) && (low_us != '0) && (ch_ext < 7'(CHANNELS));

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // ring position from the channel entry, guarded against a stray value
  assign slot_rd = ({1'b0, chan_rdata[SLOT_W-1:0]} >= (SLOT_W+1)'(WINDOW)) ?
                   '0 : chan_rdata[SLOT_W-1:0];
  assign win_raddr = {ch_idx_r, slot_rd};
  assign slot_next = (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + 1'b1;

  // running sums: drop the oldest sample, add the new one
  assign hs_next = hs_r - win_rdata[2*US_W-1:US_W] + SUM_W'(hi_r);
  assign ls_next = ls_r - win_rdata[US_W-1:0] + SUM_W'(lo_r);

  // store write ports, shared between the clearing pass and the update
  always_comb begin
    win_we     = 1'b0;
    win_waddr  = {ch_idx_r, slot_r};
    win_wdata  = {hi_r, lo_r};
    chan_we    = 1'b0;
    chan_waddr = ch_idx_r;
    chan_wdata = {hs_next, ls_next, slot_next};
    if (state == S_CLEAR) begin
      win_we     = 1'b1;
      win_waddr  = clr_cnt;
      win_wdata  = '0;
      chan_we    = 1'b1;
      chan_waddr = clr_cnt[CH_W-1:0];
      chan_wdata = '0;
    end else if (state == S_RDWIN) begin
      win_we  = 1'b1;
      chan_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[win_waddr] <= win_wdata;
    end
    win_rdata <= win_mem[win_raddr];
  end

  always_ff @(posedge clk) begin
    if (chan_we) begin
      chan_mem[chan_waddr] <= chan_wdata;
    end
    chan_rdata <= chan_mem[ch_idx_in];
  end

  // both quotients run side by side
  assign div_start = (state == S_START);
  assign total     = TOT_W'(hs_r) + TOT_W'(ls_r);
  assign duty_num  = DNUM_W'(hs_r) * DNUM_W'(PERCENT);

  pwmavg_div #(
    .NUM_W (FNUM_W),
    .DEN_W (TOT_W)
  ) u_fdiv (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (FNUM_W'(FREQ_NUM)),
    .den   (total),
    .stat  (fdiv_stat),
    .quo   (fquo)
  );

  pwmavg_div #(
    .NUM_W (DNUM_W),
    .DEN_W (TOT_W)
  ) u_ddiv (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (duty_num),
    .den   (total),
    .stat  (ddiv_stat),
    .quo   (dquo)
  );

  // frequency saturates at the field maximum
  assign fquo_ext = QW'(fquo);
  assign freq_sat = (fquo_ext > QW'(FREQ_MAX)) ? FREQ_MAX : fquo_ext[FREQ_W-1:0];

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (&clr_cnt) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          state_next = item_ok ? S_RDCH : S_OUT;
        end
      end
      S_RDCH:  state_next = S_RDWIN;
      S_RDWIN: state_next = S_START;
      S_START: state_next = S_DIV;
      S_DIV: begin
        if (!fdiv_stat.busy && !ddiv_stat.busy) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ch_r     <= channel;
      ch_idx_r <= ch_idx_in;
      hi_r     <= hi_cl;
      lo_r     <= lo_cl;
      res_freq <= '0;
      res_duty <= '0;
    end
    if (state == S_RDCH) begin
      slot_r <= slot_rd;
      hs_r   <= chan_rdata[CHE_W-1:SUM_W+SLOT_W];
      ls_r   <= chan_rdata[SUM_W+SLOT_W-1:SLOT_W];
    end
    if (state == S_RDWIN) begin
      hs_r <= hs_next;
      ls_r <= ls_next;
    end
    if (state == S_DIV && !fdiv_stat.busy && !ddiv_stat.busy) begin
      res_freq <= freq_sat;
      res_duty <= dquo[DUTY_W-1:0];
    end
  end

  // output register, holds a result until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      channel_out  <= ch_r;
      frequency_hz <= res_freq;
      duty_percent <= res_duty;
    end
  end

endmodule

[tb/sv/pwm_average_checker.sv]
module pwm_average_checker import pwmavg_pkg::*; #(
  parameter int NUM_CHANNELS = 8,
  parameter int WINDOW_LEN   = 50,
  parameter int MAX_WIDTH_US = 5000
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [CH_IN_W-1:0] channel,
  input  logic [US_W-1:0]    high_us,
  input  logic [US_W-1:0]    low_us,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [CH_IN_W-1:0] channel_out,
  input  logic [FREQ_W-1:0]  frequency_hz,
  input  logic [DUTY_W-1:0]  duty_percent,
  output int                 mismatches,
  output int                 outstanding
);

  typedef struct packed {
    logic [CH_IN_W-1:0] ch;
    logic [FREQ_W-1:0]  freq;
    logic [DUTY_W-1:0]  duty;
  } average_t;

  localparam longint unsigned FREQ_CEIL = (64'd1 << FREQ_W) - 1;

  logic [US_W-1:0] high_hist [NUM_CHANNELS][WINDOW_LEN];
  logic [US_W-1:0] low_hist  [NUM_CHANNELS][WINDOW_LEN];
  int unsigned     high_total [NUM_CHANNELS];
  int unsigned     low_total  [NUM_CHANNELS];
  int unsigned     next_slot  [NUM_CHANNELS];
  average_t        expected_averages [$];
  int              fail_count = 0;

  function automatic logic [US_W-1:0] saturate_width(input logic [US_W-1:0] w);
    return (w > MAX_WIDTH_US) ? US_W'(MAX_WIDTH_US) : w;
  endfunction

  // window update and the two truncating divisions
  function automatic average_t predict_average(input logic [CH_IN_W-1:0] ch,
                                               input logic [US_W-1:0] hi_raw,
                                               input logic [US_W-1:0] lo_raw);
    average_t          r;
    logic [US_W-1:0]   hi;
    logic [US_W-1:0]   lo;
    int unsigned       s;
    longint unsigned   total;
    longint unsigned   f;
    longint unsigned   d;
    r.ch   = ch;
    r.freq = '0;
    r.duty = '0;
    if (hi_raw != 0 && lo_raw != 0 && ch < NUM_CHANNELS) begin
      hi = saturate_width(hi_raw);
      lo = saturate_width(lo_raw);
      s  = next_slot[ch];
      high_total[ch] = high_total[ch] - high_hist[ch][s] + hi;
      low_total[ch]  = low_total[ch] - low_hist[ch][s] + lo;
      high_hist[ch][s] = hi;
      low_hist[ch][s]  = lo;
      next_slot[ch] = (s + 1 >= WINDOW_LEN) ? 0 : s + 1;
      total = longint'(high_total[ch]) + longint'(low_total[ch]);
      if (total != 0) begin
        f = (longint'(US_PER_S) * WINDOW_LEN) / total;
        d = (longint'(PERCENT) * high_total[ch]) / total;
        r.freq = (f > FREQ_CEIL) ? FREQ_W'(FREQ_CEIL) : FREQ_W'(f);
        r.duty = (d > PERCENT) ? DUTY_W'(PERCENT) : DUTY_W'(d);
      end
    end
    return r;
  endfunction

  task automatic note_mismatch(input string what);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch at %0t: %s", $time, what);
  endtask

  always @(posedge clk) begin : watch
    average_t want;
    if (rst) begin
      foreach (high_hist[c, k]) begin
        high_hist[c][k] = '0;
        low_hist[c][k]  = '0;
      end
      foreach (high_total[c]) begin
        high_total[c] = 0;
        low_total[c]  = 0;
        next_slot[c]  = 0;
      end
      expected_averages.delete();
    end else begin
      // results leave before the new item enters, so a same-edge pair stays ordered
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        if (expected_averages.size() == 0) begin
          note_mismatch($sformatf("result ch %0d freq %0d duty %0d with none pending",
                                  channel_out, frequency_hz, duty_percent));
        end else begin
          want = expected_averages.pop_front();
          if (channel_out !== want.ch || frequency_hz !== want.freq ||
              duty_percent !== want.duty)
            note_mismatch($sformatf("got ch %0d freq %0d duty %0d, expected ch %0d freq %0d duty %0d",
                                    channel_out, frequency_hz, duty_percent,
                                    want.ch, want.freq, want.duty));
        end
      end
      if (in_valid === 1'b1 && in_ready === 1'b1)
        expected_averages.push_back(predict_average(channel, high_us, low_us));
    end
    outstanding <= expected_averages.size();
    mismatches  <= fail_count;
  end

endmodule

[tb/sv/testbench.sv]
module testbench;
  import pwmavg_pkg::*;

  // run shape
  localparam int NUM_CHANNELS    = 8;
  localparam int ITEMS_PER_PHASE = 350;
  localparam int HOLD_CYCLES     = 300;
  // slowest run: ~1400 items through the block plus long sender gaps and
  // receiver stalls, the clearing pass and the hold-offs, taken several
  // times over
  localparam int CYCLE_LIMIT     = 600000;
  // a little more than the longest block latency, to catch stray results
  localparam int TAIL_CYCLES     = 40;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [CH_IN_W-1:0] channel;
  logic [US_W-1:0]    high_us;
  logic [US_W-1:0]    low_us;
  logic               out_valid;
  logic               out_ready;
  logic [CH_IN_W-1:0] channel_out;
  logic [FREQ_W-1:0]  frequency_hz;
  logic [DUTY_W-1:0]  duty_percent;

  int mismatches;
  int outstanding;

  // idling percentages, per phase: none, sender idle, receiver stall, both
  int idle_pct  = 0;
  int stall_pct = 0;
  int sender_idle_by_phase [4] = '{0, 86, 0, 16};
  int recv_stall_by_phase  [4] = '{0, 0, 86, 16};

  // long receiver hold-off: requested by the stimulus, served by the receiver
  int hold_requests = 0;
  int hold_served   = 0;

  pwm_period_duty_averager dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .channel      (channel),
    .high_us      (high_us),
    .low_us       (low_us),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .channel_out  (channel_out),
    .frequency_hz (frequency_hz),
    .duty_percent (duty_percent)
  );

  pwm_average_checker average_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .channel      (channel),
    .high_us      (high_us),
    .low_us       (low_us),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .channel_out  (channel_out),
    .frequency_hz (frequency_hz),
    .duty_percent (duty_percent),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // receiver: random stalls, or a long hold-off that lets the block back up
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_served + 1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL pwm_period_duty_averager");
    $finish;
  end

  // offer one measurement, optionally after idle cycles, and wait for its transfer
  task automatic send_measurement(input logic [CH_IN_W-1:0] ch,
                                  input logic [US_W-1:0] hi,
                                  input logic [US_W-1:0] lo);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    channel  <= ch;
    high_us  <= hi;
    low_us   <= lo;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  // sender pause until every predicted result has been seen
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // mostly plausible pwm widths, with timeouts, over-range and tiny widths mixed in
  task automatic random_measurement(output logic [CH_IN_W-1:0] ch,
                                    output logic [US_W-1:0] hi,
                                    output logic [US_W-1:0] lo);
    int kind;
    kind = $urandom_range(99);
    ch   = CH_IN_W'($urandom_range(NUM_CHANNELS - 1));
    if (kind < 6) begin
      // capture timeout on one side or both
      case ($urandom_range(2))
        0: begin hi = '0; lo = US_W'($urandom_range(8191)); end
        1: begin hi = US_W'($urandom_range(8191)); lo = '0; end
        default: begin hi = '0; lo = '0; end
      endcase
    end else if (kind < 14) begin
      // full field range, often above the saturation point
      hi = US_W'($urandom_range(8191, 1));
      lo = US_W'($urandom_range(8191, 1));
    end else if (kind < 24) begin
      // very short pulses, high frequencies
      hi = US_W'($urandom_range(16, 1));
      lo = US_W'($urandom_range(16, 1));
    end else begin
      hi = US_W'($urandom_range(5000, 1));
      lo = US_W'($urandom_range(5000, 1));
    end
  endtask

  initial begin : stimulus
    logic [CH_IN_W-1:0] ch;
    logic [US_W-1:0]    hi;
    logic [US_W-1:0]    lo;

    rst      <= 1'b1;
    in_valid <= 1'b0;
    channel  <= '0;
    high_us  <= '0;
    low_us   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, saturation, timeouts, warm-up on fresh channels
    send_measurement(3'd0, 13'd1,    13'd1);
    send_measurement(3'd0, 13'd5000, 13'd5000);
    send_measurement(3'd7, 13'd8191, 13'd8191);
    send_measurement(3'd7, 13'd5001, 13'd1);
    send_measurement(3'd3, 13'd0,    13'd100);
    send_measurement(3'd3, 13'd100,  13'd0);
    send_measurement(3'd3, 13'd0,    13'd0);
    send_measurement(3'd5, 13'd4096, 13'd2730);
    send_measurement(3'd5, 13'd2730, 13'd5461);
    send_measurement(3'd1, 13'd1,    13'd5000);
    send_measurement(3'd1, 13'd5000, 13'd1);
    send_measurement(3'd2, 13'd0,    13'd8191);
    send_measurement(3'd6, 13'd8191, 13'd0);
    send_measurement(3'd4, 13'd1234, 13'd4321);
    send_measurement(3'd7, 13'd1,    13'd1);
    drain_results();

    // random phases with different idling; hold-offs in the first and third
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = sender_idle_by_phase[phase];
      stall_pct = recv_stall_by_phase[phase];
      if (phase == 0 || phase == 2)
        hold_requests <= hold_requests + 1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        random_measurement(ch, hi, lo);
        send_measurement(ch, hi, lo);
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("PASS pwm_period_duty_averager");
    else
      $display("FAIL pwm_period_duty_averager");
    $finish;
  end

endmodule

[sim.f]
rtl/core/pwmavg_pkg.sv
rtl/core/pwmavg_div.sv
rtl/core/pwm_period_duty_averager.sv
tb/sv/pwm_average_checker.sv
tb/sv/testbench.sv
